>>> rtl/bpq_pkg.sv
`default_nettype none
package bpq_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int KEY_CAP    = 255;

    typedef enum logic [2:0] {
        OP_LINK   = 3'd0,
        OP_UNLINK = 3'd1,
        OP_NKEY   = 3'd2,
        OP_BUCKET = 3'd3,
        OP_MIN    = 3'd4,
        OP_MAX    = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_NEIGH,
        ST_FIX,
        ST_INSERT,
        ST_SCAN,
        ST_RESULT,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic read_node;
        logic take_out;
        logic fix_neigh;
        logic insert;
        logic scan_step;
        logic make_result;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic is_scan;
        logic is_store;
    } t_status;

endpackage
`default_nettype wire

>>> rtl/bpq_if.sv
`default_nettype none
interface bpq_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [9:0] node;
    logic [8:0] key;
    modport source (output valid, output operation, output node, output key, input ready);
    modport sink (input valid, input operation, input node, input key, output ready);
endinterface

interface bpq_out_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic signed [8:0]  node_key;
    logic               present;
    logic signed [10:0] first_node;
    logic [7:0]         extreme_key;
    modport source (output valid, output status, output node_key, output present,
                    output first_node, output extreme_key, input ready);
    modport sink (input valid, input status, input node_key, input present,
                  input first_node, input extreme_key, output ready);
endinterface
`default_nettype wire

>>> rtl/bpq_ctrl.sv
`default_nettype none
module bpq_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  bpq_pkg::t_status  i_status,
    output bpq_pkg::t_cmd     o_cmd
);
    bpq_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpq_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            bpq_pkg::ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_done) begin
                    n_state = bpq_pkg::ST_IDLE;
                end
            end
            bpq_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = bpq_pkg::ST_READ;
                end
            end
            bpq_pkg::ST_READ: begin
                o_cmd.read_node = 1'b1;
                if (i_status.is_scan) begin
                    n_state = bpq_pkg::ST_SCAN;
                end else if (i_status.is_store) begin
                    n_state = bpq_pkg::ST_NEIGH;
                end else begin
                    n_state = bpq_pkg::ST_RESULT;
                end
            end
            bpq_pkg::ST_NEIGH: begin
                o_cmd.take_out = 1'b1;
                n_state = bpq_pkg::ST_FIX;
            end
            bpq_pkg::ST_FIX: begin
                o_cmd.fix_neigh = 1'b1;
                n_state = bpq_pkg::ST_INSERT;
            end
            bpq_pkg::ST_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state = bpq_pkg::ST_RESULT;
            end
            bpq_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) begin
                    n_state = bpq_pkg::ST_RESULT;
                end
            end
            bpq_pkg::ST_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.make_result = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = bpq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bpq_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == bpq_pkg::ST_IDLE) else $error("ready outside idle");
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> r_state == bpq_pkg::ST_READ) else $error("no read");
    a_result_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.make_result |=> r_out_valid) else $error("result lost");
endmodule
`default_nettype wire

>>> rtl/bpq_datapath.sv
`default_nettype none
module bpq_datapath (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire  [2:0]         i_operation,
    input  wire  [9:0]         i_node,
    input  wire  [8:0]         i_key,
    input  bpq_pkg::t_cmd      i_cmd,
    output bpq_pkg::t_status   o_status,
    output logic               o_res_status,
    output logic signed [8:0]  o_node_key,
    output logic               o_present,
    output logic signed [10:0] o_first_node,
    output logic [7:0]         o_extreme_key
);
    localparam int NODES = bpq_pkg::NODE_COUNT;
    localparam int CAP   = bpq_pkg::KEY_CAP;
    localparam int NB = CAP + 1;
    localparam int NW = $clog2(NODES);
    localparam int KW = (NB > 1) ? $clog2(NB) : 1;
    localparam int LW = NW + 1;
    localparam int CW = (NODES > NB) ? NW : KW;

    logic [8:0]    m_key  [NODES];
    logic [LW-1:0] m_prev [NODES];
    logic [LW-1:0] m_next [NODES];
    logic [LW-1:0] m_head [NB];
    logic [NB-1:0] r_occ;

    logic [CW:0]   r_clr;
    logic [2:0]    r_op;
    logic [9:0]    r_node;
    logic [8:0]    r_key;
    logic [8:0]    r_nk;
    logic [LW-1:0] r_p, r_n, r_h;
    logic [7:0]    r_low, r_high;
    logic [KW:0]   r_scan;
    logic          r_found;
    logic [7:0]    r_fkey;

    logic          node_ok, key_ok, linked, is_link;
    logic [NW-1:0] vi;
    logic [KW-1:0] ki, oki;
    logic [8:0]    scan_k;

    assign node_ok = {22'd0, r_node} < NODES;
    assign key_ok  = {23'd0, r_key} <= CAP;
    assign is_link = r_op == bpq_pkg::OP_LINK;
    assign vi      = r_node[NW-1:0];
    assign ki      = r_key[KW-1:0];
    assign oki     = r_nk[KW-1:0];
    assign linked  = !r_nk[8] && ({23'd0, r_nk} <= CAP);
    assign scan_k  = (r_op == bpq_pkg::OP_MIN) ? 9'(r_scan) : 9'(CAP - int'(r_scan));

    always_comb begin
        o_status.clear_done  = r_clr[CW];
        o_status.scan_done   = r_found || ({23'd0, 9'(r_scan)} >= NB);
        o_status.is_scan     = r_op == bpq_pkg::OP_MIN || r_op == bpq_pkg::OP_MAX;
        o_status.is_store    = node_ok && ((is_link && key_ok)
                               || r_op == bpq_pkg::OP_UNLINK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_occ  <= '0;
            r_low  <= 8'(CAP);
            r_high <= '0;
        end else begin
            if (i_cmd.clear_step) begin
                if ({1'b0, r_clr[CW-1:0]} < NODES) begin
                    m_key[r_clr[NW-1:0]]  <= 9'h1FF;
                    m_prev[r_clr[NW-1:0]] <= '0;
                    m_next[r_clr[NW-1:0]] <= '0;
                end
                if ({1'b0, r_clr[CW-1:0]} < NB) begin
                    m_head[r_clr[KW-1:0]] <= '0;
                end
                if ({1'b0, r_clr[CW-1:0]} == (CW+1)'(((NODES > NB) ? NODES : NB) - 1))
                    r_clr <= {1'b1, {CW{1'b0}}};
                else
                    r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.capture) begin
                r_op   <= i_operation;
                r_node <= i_node;
                r_key  <= i_key;
            end
            if (i_cmd.read_node) begin
                r_nk <= node_ok ? m_key[vi] : 9'h1FF;
                r_p  <= m_prev[vi];
                r_n  <= m_next[vi];
                r_h  <= key_ok ? m_head[ki] : '0;
                r_scan  <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.take_out && linked) begin
                if (r_p == '0) begin
                    m_head[oki] <= r_n;
                    r_occ[oki]  <= r_n != '0;
                end else begin
                    m_next[r_p[NW-1:0] - 1'b1] <= r_n;
                end
            end
            if (i_cmd.fix_neigh) begin
                if (linked && r_n != '0)
                    m_prev[r_n[NW-1:0] - 1'b1] <= r_p;
                if (is_link && linked && r_p == '0 && oki == ki)
                    r_h <= r_n;
                else if (is_link)
                    r_h <= m_head[ki];
            end
            if (i_cmd.insert) begin
                if (is_link) begin
                    m_key[vi]  <= r_key;
                    m_prev[vi] <= '0;
                    m_next[vi] <= r_h;
                    if (r_h != '0)
                        m_prev[r_h[NW-1:0] - 1'b1] <= LW'(r_node) + 1'b1;
                    m_head[ki] <= LW'(r_node) + 1'b1;
                    r_occ[ki]  <= 1'b1;
                    if (r_key[7:0] > r_high) r_high <= r_key[7:0];
                    if (r_key[7:0] < r_low)  r_low  <= r_key[7:0];
                end else begin
                    m_key[vi]  <= 9'h1FF;
                    m_prev[vi] <= '0;
                    m_next[vi] <= '0;
                end
            end
            if (i_cmd.scan_step && !o_status.scan_done) begin
                if (r_occ[scan_k[KW-1:0]]) begin
                    r_found <= 1'b1;
                    r_fkey  <= scan_k[7:0];
                    if (r_op == bpq_pkg::OP_MIN) r_low <= scan_k[7:0];
                    else r_high <= scan_k[7:0];
                end
                r_scan <= r_scan + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.make_result) begin
            o_res_status  <= is_link && !key_ok;
            o_node_key    <= '0;
            o_present     <= 1'b0;
            o_first_node  <= '0;
            o_extreme_key <= '0;
            case (r_op)
                bpq_pkg::OP_NKEY: begin
                    o_node_key <= r_nk;
                    o_present  <= !r_nk[8];
                end
                bpq_pkg::OP_BUCKET: begin
                    o_present    <= r_h != '0;
                    o_first_node <= 11'(signed'({1'b0, r_h}) - 1);
                end
                bpq_pkg::OP_MIN: o_extreme_key <= r_found ? r_fkey : r_low;
                bpq_pkg::OP_MAX: o_extreme_key <= r_found ? r_fkey : r_high;
                default: ;
            endcase
        end
    end

    a_found_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_found) |-> r_occ[r_fkey[KW-1:0]]) else $error("scan hit empty bucket");
    a_ins_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.insert && is_link) |=> r_occ[$past(ki)]) else $error("occ miss");
    a_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.insert && is_link) |-> r_low <= $past(r_key[7:0]))
        else $error("low mark");
endmodule
`default_nettype wire

>>> rtl/bucket_priority_queue.sv
// Link and unlink pass through the read, neighbour, fix and insert states to the result state;
// a refused request and node and bucket queries go from read straight to result. Min and max
// scans step through the buckets until an occupied one is found or all KEY_CAP+1 are checked.
// One request at a time, the next taken once the result is issued; the result register lets
// the next request enter while a result waits. Reset is synchronous, active low; after reset
// a clearing pass initializes the node and bucket memories before the first request is taken.
`default_nettype none
module bucket_priority_queue (
    input wire i_clk,
    input wire i_rst_n,
    bpq_in_if.sink    i_req,
    bpq_out_if.source o_res
);
    bpq_pkg::t_cmd    cmd;
    bpq_pkg::t_status status;

    bpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bpq_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_operation   (i_req.operation),
        .i_node        (i_req.node),
        .i_key         (i_req.key),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_res_status  (o_res.status),
        .o_node_key    (o_res.node_key),
        .o_present     (o_res.present),
        .o_first_node  (o_res.first_node),
        .o_extreme_key (o_res.extreme_key)
    );
endmodule
`default_nettype wire
